### hdl/lcsd_pkg.sv
package lcsd_pkg;

	// field widths
	localparam int SAMPLE_W   = 32;
	localparam int AVG_W      = 32;
	localparam int DEV_W      = 32;
	localparam int THR_W      = 24;
	localparam int MINW_W     = 31;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT = CFG_IDX_W'(1);

	// register reset values
	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1000);
	localparam logic [MINW_W-1:0] MINW_RESET = MINW_W'(10000);

	// operand select for the shared divider
	localparam logic DIV_SEL_AVG = 1'b0;
	localparam logic DIV_SEL_DEV = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POST_PART,
		ST_WALK,
		ST_DRAIN,
		ST_LIMIT,
		ST_DECIDE,
		ST_DIV_AVG,
		ST_DIV_DEV,
		ST_POST_FULL
	} lcsd_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic walk_rd;
		logic lim_load;
		logic decide;
		logic div_start;
		logic div_sel;
		logic avg_load;
		logic dev_load;
		logic post;
		logic complete;
	} lcsd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic walk_last;
		logic pipe_busy;
		logic div_done;
		logic out_free;
	} lcsd_status_t;

endpackage

### hdl/lcsd_if.sv
// sample channel
interface lcsd_sample_if;
	import lcsd_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_weight_mg;

	modport source (output valid, output sample_weight_mg, input ready);
	modport sink (input valid, input sample_weight_mg, output ready);
endinterface

// result channel
interface lcsd_result_if;
	import lcsd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    window_complete;
	logic                    stable;
	logic                    too_light;
	logic signed [AVG_W-1:0] window_average_mg;
	logic [DEV_W-1:0]        window_max_deviation_mg;

	modport source (
		output valid, output window_complete, output stable, output too_light,
		output window_average_mg, output window_max_deviation_mg, input ready
	);
	modport sink (
		input valid, input window_complete, input stable, input too_light,
		input window_average_mg, input window_max_deviation_mg, output ready
	);
endinterface

// configuration write channel
interface lcsd_cfg_if;
	import lcsd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### hdl/lcsd_div.sv
module lcsd_div #(
	parameter int DW      = 38,
	parameter int DIVISOR = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic [DW-1:0] quotient,
	output logic          busy,
	output logic          done
);
	// floor(x / DIVISOR) = floor(x * RECIP / 2^SH) for every x below 2^DW,
	// with RECIP = ceil(2^SH / DIVISOR) and SH = DW + ceil(log2(DIVISOR))
	localparam int LW  = $clog2(DIVISOR);
	localparam int SH  = DW + LW;
	localparam int CH  = 16;
	localparam int NCH = (DW + CH) / CH;
	localparam int PW  = NCH * CH;
	localparam int PRW = DW + CH;
	localparam int AW  = PRW + 1;
	localparam int QS  = SH - CH * (NCH - 1);
	localparam int CW  = $clog2(NCH + 1);
	localparam logic [63:0]   RECIP_W = ((64'd1 << SH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
	localparam logic [PW-1:0] RECIP   = PW'(RECIP_W);

	logic [DW-1:0]  dvd_q;
	logic [PW-1:0]  rcp_q;
	logic [AW-1:0]  acc_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [PRW-1:0] partial;
	logic [AW-1:0]  acc_nxt;

	// one reciprocal chunk per cycle, low chunk first; bits shifted out are final
	always_comb begin
		partial = PRW'(dvd_q) * PRW'(rcp_q[CH-1:0]);
		acc_nxt = {1'b0, partial} + (acc_q >> CH);
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NCH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand, reciprocal chunks and partial product accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rcp_q <= RECIP;
			acc_q <= '0;
		end else if (busy_q) begin
			rcp_q <= rcp_q >> CH;
			acc_q <= acc_nxt;
		end
	end

	assign quotient = DW'(acc_q >> QS);
	assign busy     = busy_q;
	assign done     = done_q;
endmodule

### hdl/lcsd_dp.sv
module lcsd_dp #(
	parameter int WINDOW_LENGTH = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lcsd_pkg::lcsd_cmd_t                   cmd,
	output lcsd_pkg::lcsd_status_t                status,
	input  logic signed [lcsd_pkg::SAMPLE_W-1:0]  sample_weight_mg,
	input  logic                                  cfg_valid,
	input  logic [lcsd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lcsd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  window_complete,
	output logic                                  stable,
	output logic                                  too_light,
	output logic signed [lcsd_pkg::AVG_W-1:0]     window_average_mg,
	output logic [lcsd_pkg::DEV_W-1:0]            window_max_deviation_mg
);
	import lcsd_pkg::*;

	localparam int LG    = $clog2(WINDOW_LENGTH);
	localparam int POS_W = LG;
	localparam int SUM_W = SAMPLE_W + LG;
	localparam int AD_W  = SUM_W + 1;
	localparam logic signed [SUM_W-1:0] N_S      = SUM_W'(WINDOW_LENGTH);
	localparam logic [AD_W-1:0]         N_U      = AD_W'(WINDOW_LENGTH);
	localparam logic [POS_W-1:0]        LAST_POS = POS_W'(WINDOW_LENGTH - 1);

	logic [THR_W-1:0]         thr_q;
	logic [MINW_W-1:0]        minw_q;
	logic [SAMPLE_W-1:0]      mem [WINDOW_LENGTH];
	logic [POS_W-1:0]         pos_q;
	logic [POS_W-1:0]         rd_addr_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SAMPLE_W-1:0]      rd_data_s1;
	logic                     vld_s1;
	logic signed [SUM_W-1:0]  prod_s2;
	logic                     vld_s2;
	logic [AD_W-1:0]          ad_s3;
	logic                     vld_s3;
	logic [AD_W-1:0]          max_q;
	logic [AD_W-1:0]          lim_thr_q;
	logic [AD_W-1:0]          lim_w_q;
	logic                     dev_ok_q;
	logic                     heavy_q;
	logic [AVG_W-1:0]         avg_q;
	logic [DEV_W-1:0]         dev_q;
	logic                     out_valid_q;
	logic                     out_complete_q;
	logic                     out_stable_q;
	logic                     out_light_q;
	logic [AVG_W-1:0]         out_avg_q;
	logic [DEV_W-1:0]         out_dev_q;

	logic signed [SUM_W-1:0]  sample_ext;
	logic signed [SUM_W-1:0]  rd_ext;
	logic signed [AD_W-1:0]   sum_wide;
	logic signed [AD_W-1:0]   diff;
	logic [AD_W-1:0]          ad;
	logic [AD_W-1:0]          abs_sum;
	logic [AD_W-1:0]          dividend;
	logic [AD_W-1:0]          quotient;
	logic [AD_W-1:0]          neg_quo;
	logic                     div_busy;
	logic                     div_done;
	logic                     last;
	logic                     out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			minw_q <= MINW_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD:  thr_q  <= cfg_wdata[THR_W-1:0];
				REG_MIN_WEIGHT: minw_q <= cfg_wdata[MINW_W-1:0];
				default: ;
			endcase
		end
	end

	assign last       = pos_q == LAST_POS;
	assign sample_ext = {{LG{sample_weight_mg[SAMPLE_W-1]}}, sample_weight_mg};
	assign sum_wide   = {sum_q[SUM_W-1], sum_q};

	// write position and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.accept) begin
				pos_q <= last ? '0 : pos_q + POS_W'(1);
				sum_q <= sum_q + sample_ext;
			end else if (cmd.post && cmd.complete) begin
				sum_q <= '0;
			end
		end
	end

	// sample memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[pos_q] <= sample_weight_mg;
		end
		if (cmd.walk_rd) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	// walk address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
		end else if (cmd.accept && last) begin
			rd_addr_q <= '0;
		end else if (cmd.walk_rd) begin
			rd_addr_q <= rd_addr_q + POS_W'(1);
		end
	end

	// deviation pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.walk_rd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// scaled sample minus sum, absolute value
	always_comb begin
		rd_ext = {{LG{rd_data_s1[SAMPLE_W-1]}}, rd_data_s1};
		diff   = $signed({prod_s2[SUM_W-1], prod_s2}) - sum_wide;
		ad     = diff[AD_W-1] ? AD_W'(0) - AD_W'(diff) : AD_W'(diff);
	end

	// product and deviation stages, running maximum
	always_ff @(posedge clk) begin
		prod_s2 <= rd_ext * N_S;
		ad_s3   <= ad;
		if (cmd.accept && last) begin
			max_q <= '0;
		end else if (vld_s3 && (ad_s3 > max_q)) begin
			max_q <= ad_s3;
		end
	end

	// scaled limits and verdict
	always_ff @(posedge clk) begin
		if (cmd.lim_load) begin
			lim_thr_q <= AD_W'(thr_q) * N_U;
			lim_w_q   <= AD_W'(minw_q) * N_U;
		end
		if (cmd.decide) begin
			dev_ok_q <= max_q <= lim_thr_q;
			heavy_q  <= sum_wide > $signed(lim_w_q);
		end
	end

	// divider operands and results
	always_comb begin
		abs_sum  = sum_q[SUM_W-1] ? AD_W'(0) - AD_W'(sum_wide) : AD_W'(sum_wide);
		dividend = (cmd.div_sel == DIV_SEL_DEV) ? max_q : abs_sum;
		neg_quo  = AD_W'(0) - quotient;
	end

	lcsd_div #(
		.DW      (AD_W),
		.DIVISOR (WINDOW_LENGTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.quotient (quotient),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.avg_load) begin
			avg_q <= sum_q[SUM_W-1] ? neg_quo[AVG_W-1:0] : quotient[AVG_W-1:0];
		end
		if (cmd.dev_load) begin
			dev_q <= quotient[DEV_W-1:0];
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_complete_q <= cmd.complete;
			out_stable_q   <= cmd.complete & dev_ok_q & heavy_q;
			out_light_q    <= cmd.complete & dev_ok_q & ~heavy_q;
			out_avg_q      <= cmd.complete ? avg_q : '0;
			out_dev_q      <= cmd.complete ? dev_q : '0;
		end
	end

	assign out_valid               = out_valid_q;
	assign window_complete         = out_complete_q;
	assign stable                  = out_stable_q;
	assign too_light               = out_light_q;
	assign window_average_mg       = $signed(out_avg_q);
	assign window_max_deviation_mg = out_dev_q;

	// status to controller
	always_comb begin
		status.last      = last;
		status.walk_last = rd_addr_q == LAST_POS;
		status.pipe_busy = vld_s1 | vld_s2 | vld_s3;
		status.div_done  = div_done;
		status.out_free  = out_free;
	end

`ifndef SYNTHESIS
	// no sample enters while a deviation walk is in flight
	a_accept_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(vld_s1 || vld_s2 || vld_s3))
		else $error("sample accepted during deviation walk");

	// a result is loaded only when the output register can take it
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> out_free)
		else $error("result loaded over a pending transfer");

	// divider is never restarted mid-division
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
`endif
endmodule

### hdl/lcsd_ctrl.sv
module lcsd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lcsd_pkg::lcsd_status_t status,
	output lcsd_pkg::lcsd_cmd_t    cmd
);
	import lcsd_pkg::*;

	lcsd_state_t state_q;
	lcsd_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = status.last ? ST_WALK : ST_POST_PART;
				end
			end
			ST_POST_PART: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (status.walk_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_nxt = ST_LIMIT;
				end
			end
			ST_LIMIT:  state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = ST_DIV_AVG;
			ST_DIV_AVG: begin
				if (status.div_done) begin
					state_nxt = ST_DIV_DEV;
				end
			end
			ST_DIV_DEV: begin
				if (status.div_done) begin
					state_nxt = ST_POST_FULL;
				end
			end
			ST_POST_FULL: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready      = state_q == ST_IDLE;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.walk_rd   = state_q == ST_WALK;
		cmd.lim_load  = state_q == ST_LIMIT;
		cmd.decide    = state_q == ST_DECIDE;
		cmd.div_start = (state_q == ST_DECIDE)
			|| ((state_q == ST_DIV_AVG) && status.div_done);
		cmd.div_sel   = (state_q == ST_DIV_AVG) ? DIV_SEL_DEV : DIV_SEL_AVG;
		cmd.avg_load  = (state_q == ST_DIV_AVG) && status.div_done;
		cmd.dev_load  = (state_q == ST_DIV_DEV) && status.div_done;
		cmd.post      = ((state_q == ST_POST_PART) || (state_q == ST_POST_FULL))
			&& status.out_free;
		cmd.complete  = state_q == ST_POST_FULL;
	end
endmodule

### hdl/load_cell_stability_detector.sv
// Load cell stability detector. Each sample transfer (signed mg) is stored in a
// window of WINDOW_LENGTH entries and gives exactly one result transfer. A sample
// that does not close the window returns an all-zero result. The sample that
// closes the window starts a walk over the sample memory (one read per cycle
// through a 3-stage scale/subtract/max pipeline), then two passes of a divider
// by WINDOW_LENGTH that multiplies by the reciprocal in three 16-bit steps, one
// for the average and one for the largest deviation. The verdict is exact:
// stable when max|N*x - sum| <= N*threshold and sum > N*min_weight, too_light
// when the deviation passes but the weight does not. A result that waits in the
// output register does not hold off the next sample. Register writes are taken
// in every cycle and must be made only while the block is idle.
module load_cell_stability_detector #(
	parameter int WINDOW_LENGTH = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lcsd_sample_if.sink          in_ch,
	lcsd_result_if.source        out_ch,
	lcsd_cfg_if.sink             cfg_ch
);
	import lcsd_pkg::*;

	lcsd_cmd_t    cmd;
	lcsd_status_t status;

	// configuration writes never stall
	assign cfg_ch.ready = 1'b1;

	lcsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lcsd_dp #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_dp (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.cmd                     (cmd),
		.status                  (status),
		.sample_weight_mg        (in_ch.sample_weight_mg),
		.cfg_valid               (cfg_ch.valid),
		.cfg_index               (cfg_ch.index),
		.cfg_wdata               (cfg_ch.wdata),
		.out_valid               (out_ch.valid),
		.out_ready               (out_ch.ready),
		.window_complete         (out_ch.window_complete),
		.stable                  (out_ch.stable),
		.too_light               (out_ch.too_light),
		.window_average_mg       (out_ch.window_average_mg),
		.window_max_deviation_mg (out_ch.window_max_deviation_mg)
	);
endmodule

### dv/load_cell_stability_detector_tb.sv
`timescale 1ns / 1ps

module load_cell_stability_detector_tb;
	import lcsd_pkg::*;

	localparam int     WINDOW_LENGTH     = 20;
	localparam int     PHASES            = 16;
	localparam int     WINDOWS_PER_PHASE = 5;
	localparam int     HOLD_CYCLES       = 400;
	localparam int     SETTLE_CYCLES     = 160;
	localparam int     CYCLE_LIMIT       = 1000000;
	localparam longint MG_MAX            = 64'sd2147483647;
	localparam longint MG_MIN            = -64'sd2147483648;

	// shapes of a generated window
	typedef enum {WIN_STEADY, WIN_BORDER, WIN_FLAT, WIN_NOISE, WIN_DRIFT} window_kind_t;

	// one result transfer
	typedef struct {
		logic                    complete;
		logic                    stable;
		logic                    too_light;
		logic signed [AVG_W-1:0] avg;
		logic [DEV_W-1:0]        dev;
	} verdict_t;

	// tracks the window contents and registers, predicts and checks every verdict
	class stability_checker;
		bit [THR_W-1:0]  threshold  = THR_RESET;
		bit [MINW_W-1:0] min_weight = MINW_RESET;
		longint          window_mg[WINDOW_LENGTH];
		int              fill;
		longint          total;
		verdict_t        pending_verdicts[$];
		int              errors, samples, windows, stable_windows, light_windows, reg_writes;

		function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_THRESHOLD:  threshold = data[THR_W-1:0];
				REG_MIN_WEIGHT: min_weight = data[MINW_W-1:0];
				default: ;
			endcase
		endfunction

		// store the sample; on the window end work out average, deviation and verdict
		function verdict_t weigh_sample(logic signed [SAMPLE_W-1:0] w);
			verdict_t v;
			longint   dev;
			longint   peak;
			bit       dev_ok;
			bit       heavy;
			v = '{default: '0};
			if (fill >= WINDOW_LENGTH)
				fill = 0;
			window_mg[fill] = w;
			total += w;
			fill++;
			if (fill < WINDOW_LENGTH)
				return v;
			peak = 0;
			foreach (window_mg[i]) begin
				dev = WINDOW_LENGTH * window_mg[i] - total;
				if (dev < 0)
					dev = -dev;
				if (dev > peak)
					peak = dev;
			end
			// exact comparisons on the N-scaled terms
			dev_ok      = peak <= WINDOW_LENGTH * longint'(threshold);
			heavy       = total > WINDOW_LENGTH * longint'(min_weight);
			v.complete  = 1'b1;
			v.stable    = dev_ok && heavy;
			v.too_light = dev_ok && !heavy;
			v.avg       = AVG_W'(total / WINDOW_LENGTH);
			v.dev       = DEV_W'(peak / WINDOW_LENGTH);
			fill  = 0;
			total = 0;
			return v;
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] w);
			samples++;
			pending_verdicts.push_back(weigh_sample(w));
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				$error("result transfer with no sample waiting for it");
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.complete !== want.complete) begin
				$error("window_complete: expected %0d, got %0d", want.complete, got.complete);
				errors++;
			end
			if (got.stable !== want.stable) begin
				$error("stable: expected %0d, got %0d", want.stable, got.stable);
				errors++;
			end
			if (got.too_light !== want.too_light) begin
				$error("too_light: expected %0d, got %0d", want.too_light, got.too_light);
				errors++;
			end
			if (got.avg !== want.avg) begin
				$error("window_average_mg: expected %0d, got %0d", want.avg, got.avg);
				errors++;
			end
			if (got.dev !== want.dev) begin
				$error("window_max_deviation_mg: expected %0d, got %0d", want.dev, got.dev);
				errors++;
			end
			if (want.complete) begin
				windows++;
				if (want.stable)
					stable_windows++;
				if (want.too_light)
					light_windows++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct;
	int   snk_stall_pct;
	bit   hold_req;
	int   cycles;

	stability_checker sb = new;

	lcsd_sample_if in_ch ();
	lcsd_result_if out_ch ();
	lcsd_cfg_if    cfg_ch ();

	load_cell_stability_detector #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		verdict_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.complete  = out_ch.window_complete;
			got.stable    = out_ch.stable;
			got.too_light = out_ch.too_light;
			got.avg       = out_ch.window_average_mg;
			got.dev       = out_ch.window_max_deviation_mg;
			sb.check_verdict(got);
		end
	end

	// result receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] clamp_mg(longint v);
		if (v > MG_MAX)
			return SAMPLE_W'(MG_MAX);
		if (v < MG_MIN)
			return SAMPLE_W'(MG_MIN);
		return SAMPLE_W'(v);
	endfunction

	// wait at falling edges until every verdict has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (sb.pending_verdicts.size() != 0);
	endtask

	// one sample transfer; valid stays high so the next one can follow at once
	task automatic send_sample(logic signed [SAMPLE_W-1:0] w);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.sample_weight_mg <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.take_sample(w);
		@(negedge clk);
	endtask

	// one register write transfer; the caller lowers valid after the last one
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.note_register(idx, data);
		@(negedge clk);
	endtask

	// a full window of one shape, with an optional drain pause before sample pause_at
	task automatic send_window(window_kind_t kind, int pause_at);
		longint                     base;
		longint                     slope;
		longint                     thr;
		longint                     minw;
		int unsigned                spread;
		int unsigned                amp;
		bit                         bump;
		logic signed [SAMPLE_W-1:0] w;
		thr    = longint'(sb.threshold);
		minw   = longint'(sb.min_weight);
		bump   = $urandom_range(1);
		spread = int'(thr) + 16;
		amp    = $urandom_range(int'(thr));
		slope  = longint'($urandom_range(8192)) - 4096;
		case (kind)
			WIN_STEADY: base = minw + longint'($urandom_range(2 * spread)) - spread;
			WIN_BORDER: base = minw + longint'($urandom_range(1));
			WIN_FLAT:   base = minw + bump;
			default:    base = longint'($signed($urandom()));
		endcase
		for (int i = 0; i < WINDOW_LENGTH; i++) begin
			case (kind)
				WIN_STEADY: w = clamp_mg(base + longint'($urandom_range(2 * amp)) - amp);
				// half at base - thr, half at base + thr: deviation exactly on the limit, or just past it when bump adds 1
				WIN_BORDER: w = clamp_mg(((i % 2) ? base + thr : base - thr)
					+ ((bump && i == WINDOW_LENGTH - 1) ? 1 : 0));
				WIN_FLAT:   w = clamp_mg(base);
				WIN_NOISE:  w = $urandom();
				default:    w = clamp_mg(base + i * slope);
			endcase
			if (i == pause_at) begin
				in_ch.valid <= 1'b0;
				wait_drained();
			end
			send_sample(w);
		end
	endtask

	// register settings for one phase, extremes first
	task automatic configure_phase(int phase);
		logic [THR_W-1:0]  thr;
		logic [MINW_W-1:0] minw;
		case (phase)
			1: begin
				thr  = '0;
				minw = '0;
			end
			2: begin
				thr  = '1;
				minw = '1;
			end
			3: begin
				thr  = THR_RESET;
				minw = MINW_RESET;
			end
			default: begin
				case ($urandom_range(3))
					0: thr = THR_W'($urandom_range(255));
					1: thr = THR_W'($urandom_range(65535));
					2: thr = THR_W'($urandom());
					default: thr = '1;
				endcase
				case ($urandom_range(3))
					0: minw = MINW_W'($urandom_range(100000));
					1: minw = MINW_W'($urandom());
					2: minw = '0;
					default: minw = '1;
				endcase
			end
		endcase
		// unused register indexes must be ignored
		if ($urandom_range(1))
			write_register(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_MIN_WEIGHT + 1)),
				$urandom());
		write_register(REG_THRESHOLD, {(CFG_DATA_W - THR_W)'($urandom()), thr});
		write_register(REG_MIN_WEIGHT, {(CFG_DATA_W - MINW_W)'($urandom()), minw});
		cfg_ch.valid <= 1'b0;
	endtask

	// main sequence
	initial begin
		logic signed [SAMPLE_W-1:0] extremes[20];
		window_kind_t               kind;
		int                         pick;
		extremes = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 32'sh5555_5555,
			32'shAAAA_AAAA, 10000, 10001, 9999, -10000, 1000, -1000, 32'sh0000_FFFF,
			32'shFFFF_0000, 32'sh4000_0000, 32'shC000_0000, 12345, 20000, 10000};
		arst_n                 = 1'b0;
		in_ch.valid            = 1'b0;
		in_ch.sample_weight_mg = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = '0;
		cfg_ch.wdata           = '0;
		src_idle_pct           = 0;
		snk_stall_pct          = 0;
		hold_req               = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed window of extreme samples under the reset settings
		foreach (extremes[i])
			send_sample(extremes[i]);

		// random phases, each with its own settings and pacing
		for (int phase = 1; phase <= PHASES; phase++) begin
			in_ch.valid <= 1'b0;
			wait_drained();
			case (phase % 4)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 85;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 85;
				end
				default: begin
					src_idle_pct  = 17;
					snk_stall_pct = 17;
				end
			endcase
			configure_phase(phase);
			for (int win = 0; win < WINDOWS_PER_PHASE; win++) begin
				pick = $urandom_range(99);
				if (pick < 45)
					kind = WIN_STEADY;
				else if (pick < 60)
					kind = WIN_BORDER;
				else if (pick < 70)
					kind = WIN_FLAT;
				else if (pick < 85)
					kind = WIN_NOISE;
				else
					kind = WIN_DRIFT;
				// long receiver hold-off while samples keep coming
				if (phase == 3 && win == 2)
					hold_req = 1'b1;
				send_window(kind, (phase == 5 && win == 2) ? 7 : -1);
			end
		end

		// drain and let the block settle
		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Checked %0d samples in %0d windows (%0d stable, %0d too light)",
			sb.samples, sb.windows, sb.stable_windows, sb.light_windows);
		$display("Register writes: %0d across %0d settings, four pacing modes",
			sb.reg_writes, PHASES + 1);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
